[hw/rtl/accelerator_utilization_fuser_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the utilization fuser core
// Implication checks sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ACCELERATOR_UTILIZATION_FUSER_CORE_MACROS_SVH
`define ACCELERATOR_UTILIZATION_FUSER_CORE_MACROS_SVH

// same-cycle implication
`define AUF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AUF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/auf_pkg.sv]
// ----------------------------------------------------------------------------
// auf_pkg
// Widths, constants and shared types of the utilization fuser.
// ----------------------------------------------------------------------------
`default_nettype none

package auf_pkg;

  // sample field widths
  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int POWER_W    = 16;
  localparam int RATE_W     = 24;
  localparam int LEVEL_W    = 15;
  localparam int THR_W      = 15;
  localparam int WEIGHT_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // levels in 1/256 percent
  localparam logic [LEVEL_W-1:0] FULL_LEVEL      = 15'd25600;
  localparam logic [LEVEL_W-1:0] LOW_POWER_LEVEL = 15'd1280;   // 5 percent
  localparam logic [LEVEL_W-1:0] HIGH_INF_LEVEL  = 15'd10240;  // 40 percent
  localparam logic [LEVEL_W-1:0] GAP_LEVEL       = 15'd12800;  // 50 percent
  localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT    = 9'd256;
  localparam int WEIGHT_FRAC = 8;

  // power map: num * 25600 = (num * 25) << 10
  localparam int P25_W       = POWER_W + 5;
  localparam int POWER_SHIFT = 10;
  localparam int PDVD_W      = P25_W + POWER_SHIFT;

  // inference map: delta * 25600e6 = (delta * 5^8) << 16
  localparam int X_STEPS = 8;
  localparam int XM_W    = COUNT_W + 19;
  localparam int X_SHIFT = 16;
  localparam int X_W     = XM_W + X_SHIFT;
  localparam int D_W     = TIME_W + RATE_W;
  localparam int DS_W    = D_W + LEVEL_W - 1;
  localparam int DIV_W   = (X_W > DS_W) ? X_W : DS_W;

  // serial multiply of elapsed time by rate, one rate bit per step
  localparam int MUL_STEPS  = RATE_W;
  localparam int STEP_CNT_W = $clog2(MUL_STEPS);

  // fusion arithmetic
  localparam int PROD_W      = WEIGHT_W + LEVEL_W;
  localparam int NORM_W      = PROD_W + 1 - WEIGHT_FRAC;
  localparam int STALL_SUM_W = 18;
  localparam int DIV10_W     = 20;
  localparam logic [DIV10_W-1:0] DIV10_MULT = 20'd838861;  // ceil(2^23 / 10)
  localparam int DIV10_SHIFT = 23;
  localparam int Q10_W       = STALL_SUM_W + DIV10_W;

  // register reset values
  localparam logic [POWER_W-1:0]  RST_IDLE_POWER   = 16'd1000;
  localparam logic [POWER_W-1:0]  RST_ACTIVE_POWER = 16'd2500;
  localparam logic [RATE_W-1:0]   RST_RATE         = 24'd30;
  localparam logic [THR_W-1:0]    RST_STALL_PWR    = 15'd15360;
  localparam logic [THR_W-1:0]    RST_STALL_INF    = 15'd2560;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT       = 9'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_POWER,
    REG_ACTIVE_POWER,
    REG_EXPECTED_RATE,
    REG_STALL_POWER_THR,
    REG_STALL_INF_THR,
    REG_POWER_WEIGHT,
    REG_INF_WEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic [POWER_W-1:0] power_mw;
    logic [COUNT_W-1:0] inference_count;
    logic [TIME_W-1:0]  timestamp_us;
  } auf_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] power_level;
    logic [LEVEL_W-1:0] inference_level;
    logic [LEVEL_W-1:0] utilization;
    logic               stall_seen;
    logic               healthy;
    logic [COUNT_W-1:0] count_delta;
  } auf_out_t;

  typedef struct packed {
    logic [POWER_W-1:0]  idle_power_mw;
    logic [POWER_W-1:0]  active_power_mw;
    logic [RATE_W-1:0]   expected_rate;
    logic [THR_W-1:0]    stall_power_threshold;
    logic [THR_W-1:0]    stall_inference_threshold;
    logic [WEIGHT_W-1:0] power_weight_q8;
    logic [WEIGHT_W-1:0] inference_weight_q8;
  } auf_cfg_t;

  typedef struct packed {
    logic capture;
    logic mul_step;
    logic x_step;
    logic take_pl;
    logic start_inf;
    logic take_il;
    logic fuse1;
    logic fuse2;
    logic load_out;
  } auf_cmd_t;

  typedef struct packed {
    logic div_busy;
  } auf_status_t;

endpackage

`default_nettype wire

[hw/rtl/auf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// auf_cfg_regs
// Configuration register bank, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module auf_cfg_regs import auf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output auf_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_power_mw             <= RST_IDLE_POWER;
      cfg.active_power_mw           <= RST_ACTIVE_POWER;
      cfg.expected_rate             <= RST_RATE;
      cfg.stall_power_threshold     <= RST_STALL_PWR;
      cfg.stall_inference_threshold <= RST_STALL_INF;
      cfg.power_weight_q8           <= RST_WEIGHT;
      cfg.inference_weight_q8       <= RST_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IDLE_POWER:      cfg.idle_power_mw <= cfg_data[POWER_W-1:0];
        REG_ACTIVE_POWER:    cfg.active_power_mw <= cfg_data[POWER_W-1:0];
        REG_EXPECTED_RATE:   cfg.expected_rate <= cfg_data[RATE_W-1:0];
        REG_STALL_POWER_THR: cfg.stall_power_threshold <= cfg_data[THR_W-1:0];
        REG_STALL_INF_THR:   cfg.stall_inference_threshold <= cfg_data[THR_W-1:0];
        REG_POWER_WEIGHT:    cfg.power_weight_q8 <= cfg_data[WEIGHT_W-1:0];
        REG_INF_WEIGHT:      cfg.inference_weight_q8 <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/auf_divider.sv]
// ----------------------------------------------------------------------------
// auf_divider
// Bit-serial quotient search, one quotient bit per cycle, capped at full
// level. Finds the largest q <= 25600 with q * divisor <= dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module auf_divider import auf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [X_W-1:0]     dividend,
  input  logic [D_W-1:0]     divisor,
  output logic               busy,
  output logic [LEVEL_W-1:0] quotient
);

  `include "accelerator_utilization_fuser_core_macros.svh"

  localparam logic [LEVEL_W-1:0] TOP_BIT = {1'b1, {(LEVEL_W-1){1'b0}}};

  logic [X_W-1:0]     rem;
  logic [DS_W-1:0]    dsh;    // divisor aligned to the current quotient bit
  logic [LEVEL_W-1:0] mask;
  logic [LEVEL_W-1:0] trial;
  logic [DIV_W-1:0]   rem_ext;
  logic [DIV_W-1:0]   dsh_ext;
  logic [DIV_W-1:0]   rem_diff;
  logic               fits;

  assign trial    = quotient | mask;
  assign rem_ext  = DIV_W'(rem);
  assign dsh_ext  = DIV_W'(dsh);
  assign rem_diff = rem_ext - dsh_ext;
  assign fits     = (trial <= FULL_LEVEL) && (dsh_ext <= rem_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mask[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {divisor, {(LEVEL_W-1){1'b0}}};
      mask     <= TOP_BIT;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        quotient <= trial;
        rem      <= rem_diff[X_W-1:0];
      end
      dsh  <= dsh >> 1;
      mask <= mask >> 1;
    end
  end

  `AUF_ASSERT_IMPL(a_no_restart, start, !busy, "divider restarted mid-search")
  `AUF_ASSERT_IMPL(a_quot_capped, $fell(busy), quotient <= FULL_LEVEL,
                   "quotient above full level")

endmodule

`default_nettype wire

[hw/rtl/auf_ctrl.sv]
// ----------------------------------------------------------------------------
// auf_ctrl
// Sequencer: capture, serial multiply with power division, inference
// division, two fusion steps, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module auf_ctrl import auf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  auf_status_t status,
  output auf_cmd_t    cmd
);

  `include "accelerator_utilization_fuser_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LAUNCH,
    S_IDIV,
    S_FUSE1,
    S_FUSE2,
    S_OUT
  } state_t;

  state_t                state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.x_step   = (step_cnt < STEP_CNT_W'(X_STEPS));
      end
      S_LAUNCH: begin
        cmd.take_pl   = 1'b1;
        cmd.start_inf = 1'b1;
      end
      S_IDIV:  cmd.take_il = !status.div_busy;
      S_FUSE1: cmd.fuse1 = 1'b1;
      S_FUSE2: cmd.fuse2 = 1'b1;
      S_OUT:   cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          step_cnt <= '0;
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          if (step_cnt == STEP_CNT_W'(MUL_STEPS - 1)) begin
            state <= S_LAUNCH;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        S_LAUNCH: state <= S_IDIV;
        S_IDIV:   if (!status.div_busy) state <= S_FUSE1;
        S_FUSE1:  state <= S_FUSE2;
        S_FUSE2:  state <= S_OUT;
        S_OUT:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // power division shares the divider and must be done by end of multiply
  `AUF_ASSERT_IMPL(a_pdiv_done, cmd.take_pl, !status.div_busy,
                   "power division still running at launch")
  `AUF_ASSERT_IMPL(a_idle_div, in_ready, !status.div_busy,
                   "divider busy while taking a sample")
  `AUF_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_valid || out_ready,
                   "result overwritten before transaction")

endmodule

`default_nettype wire

[hw/rtl/auf_datapath.sv]
// ----------------------------------------------------------------------------
// auf_datapath
// Sample history, operand setup, serial multipliers, shared divider and
// fusion arithmetic, plus the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module auf_datapath import auf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  auf_cmd_t    cmd,
  output auf_status_t status,
  input  auf_in_t     in_data,
  input  auf_cfg_t    cfg,
  output auf_out_t    out_data
);

  // history
  logic [COUNT_W-1:0] last_count;
  logic [TIME_W-1:0]  last_time;
  logic               have_last;

  // capture-time operands
  logic [COUNT_W-1:0] delta;
  logic [TIME_W-1:0]  dt;
  logic [POWER_W-1:0] pnum;
  logic [POWER_W-1:0] pden;
  logic [P25_W-1:0]   p25;
  logic [PDVD_W-1:0]  pdvd;

  // sample registers
  logic [COUNT_W-1:0] count_delta;
  logic               zero_den;
  logic [XM_W-1:0]    x_acc;
  logic [D_W-1:0]     mul_a;
  logic [RATE_W-1:0]  mul_b;
  logic [D_W-1:0]     d_acc;

  // divider hookup
  logic               div_start;
  logic [X_W-1:0]     div_dividend;
  logic [D_W-1:0]     div_divisor;
  logic               div_busy;
  logic [LEVEL_W-1:0] div_quot;

  // fusion
  logic [LEVEL_W-1:0]     pl;
  logic [LEVEL_W-1:0]     il;
  logic [WEIGHT_W-1:0]    pw;
  logic [WEIGHT_W-1:0]    iw;
  logic [LEVEL_W-1:0]     pth;
  logic [LEVEL_W-1:0]     ith;
  logic [LEVEL_W-1:0]     gap;
  logic [PROD_W-1:0]      prod_p;
  logic [PROD_W-1:0]      prod_i;
  logic [STALL_SUM_W-1:0] s_stall;
  logic                   stall;
  logic                   healthy;
  logic [Q10_W-1:0]       prod10;
  logic [LEVEL_W-1:0]     q10;
  logic [PROD_W:0]        norm_sum;
  logic [NORM_W-1:0]      norm;
  logic [LEVEL_W-1:0]     util;

  assign delta = have_last ? in_data.inference_count - last_count : '0;
  assign dt    = in_data.timestamp_us - last_time;

  // linear power map; inverted when active is below idle
  always_comb begin
    pnum = '0;
    pden = '0;
    if (cfg.active_power_mw == cfg.idle_power_mw) begin
      pnum = (in_data.power_mw > cfg.idle_power_mw) ? POWER_W'(1) : '0;
      pden = POWER_W'(1);
    end else if (cfg.active_power_mw > cfg.idle_power_mw) begin
      if (in_data.power_mw > cfg.idle_power_mw) begin
        pnum = in_data.power_mw - cfg.idle_power_mw;
      end
      pden = cfg.active_power_mw - cfg.idle_power_mw;
    end else begin
      if (in_data.power_mw < cfg.idle_power_mw) begin
        pnum = cfg.idle_power_mw - in_data.power_mw;
      end
      pden = cfg.idle_power_mw - cfg.active_power_mw;
    end
  end

  assign p25  = P25_W'({pnum, 4'b0}) + P25_W'({pnum, 3'b0}) + P25_W'(pnum);
  assign pdvd = {p25, {POWER_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      last_time  <= '0;
      have_last  <= 1'b0;
    end else if (cmd.capture) begin
      last_count <= in_data.inference_count;
      last_time  <= in_data.timestamp_us;
      have_last  <= 1'b1;
    end
  end

  // delta * 5^8 by repeated x5, dt * rate by shift-add over rate bits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      count_delta <= delta;
      zero_den    <= (dt == '0) || (cfg.expected_rate == '0);
      x_acc       <= XM_W'(delta);
      mul_a       <= D_W'(dt);
      mul_b       <= cfg.expected_rate;
      d_acc       <= '0;
    end else if (cmd.mul_step) begin
      if (cmd.x_step) x_acc <= x_acc + {x_acc[XM_W-3:0], 2'b00};
      if (mul_b[0]) d_acc <= d_acc + mul_a;
      mul_a <= {mul_a[D_W-2:0], 1'b0};
      mul_b <= mul_b >> 1;
    end
  end

  assign div_start    = cmd.capture || cmd.start_inf;
  assign div_dividend = cmd.capture ? X_W'(pdvd) : {x_acc, {X_SHIFT{1'b0}}};
  assign div_divisor  = cmd.capture ? D_W'(pden) : d_acc;

  auf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  assign status.div_busy = div_busy;

  assign pw  = (cfg.power_weight_q8 > UNIT_WEIGHT) ? UNIT_WEIGHT : cfg.power_weight_q8;
  assign iw  = (cfg.inference_weight_q8 > UNIT_WEIGHT) ? UNIT_WEIGHT
                                                       : cfg.inference_weight_q8;
  assign pth = (cfg.stall_power_threshold > FULL_LEVEL) ? FULL_LEVEL
                                                        : cfg.stall_power_threshold;
  assign ith = (cfg.stall_inference_threshold > FULL_LEVEL) ? FULL_LEVEL
                                                            : cfg.stall_inference_threshold;
  assign gap = (pl > il) ? pl - il : il - pl;

  // x / 10 as (x * ceil(2^23/10)) >> 23, exact for x below 2^22
  assign prod10   = Q10_W'(s_stall) * Q10_W'(DIV10_MULT);
  assign norm_sum = (PROD_W+1)'(prod_p) + (PROD_W+1)'(prod_i);
  assign util     = stall ? q10
                  : (norm > NORM_W'(FULL_LEVEL)) ? FULL_LEVEL : norm[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.take_pl) pl <= div_quot;
    if (cmd.take_il) il <= zero_den ? '0 : div_quot;
    if (cmd.fuse1) begin
      prod_p  <= PROD_W'(pw) * PROD_W'(pl);
      prod_i  <= PROD_W'(iw) * PROD_W'(il);
      s_stall <= STALL_SUM_W'({pl, 1'b0}) + STALL_SUM_W'(pl)
               + STALL_SUM_W'({il, 3'b0}) - STALL_SUM_W'(il);
      stall   <= (pl > pth) && (il < ith);
      healthy <= !(((pl < LOW_POWER_LEVEL) && (il > HIGH_INF_LEVEL)) || (gap > GAP_LEVEL));
    end
    if (cmd.fuse2) begin
      q10  <= prod10[DIV10_SHIFT +: LEVEL_W];
      norm <= norm_sum[PROD_W:WEIGHT_FRAC];
    end
    if (cmd.load_out) begin
      out_data.power_level     <= pl;
      out_data.inference_level <= il;
      out_data.utilization     <= util;
      out_data.stall_seen      <= stall;
      out_data.healthy         <= healthy;
      out_data.count_delta     <= count_delta;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/accelerator_utilization_fuser_core.sv]
// ----------------------------------------------------------------------------
// accelerator_utilization_fuser_core
// Each telemetry transaction runs as follows from acceptance until its result
// is offered: the elapsed time is multiplied by the expected rate one rate
// bit per cycle (the power quotient is found in the shared divider
// meanwhile), a launch step then starts the inference quotient in that
// divider, followed by two fusion steps and the output load.
// A sample is taken only while the core is idle; a finished result sits in
// the output register, so the next sample may be accepted before it is taken,
// and a new result waits for that register to empty. Configuration writes
// are always accepted (cfg_ready is always high) and belong in idle periods
// only.
// ----------------------------------------------------------------------------
`default_nettype none

module accelerator_utilization_fuser_core import auf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  auf_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output auf_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  auf_cfg_t    cfg;
  auf_cmd_t    cmd;
  auf_status_t status;

  assign cfg_ready = 1'b1;

  auf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  auf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  auf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg      (cfg),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
